[sv/tmpm_pkg.sv]
// Package for the trie multi-pattern matcher.
// Holds default sizes, the queue entry types and the operation codes.
// No dependencies.
`default_nettype none
package tmpm_pkg;
  localparam int NODES_DEF     = 4096;
  localparam int MAX_DEPTH_DEF = 32;
  localparam int TEXT_MAX_DEF  = 65536;
  localparam int CMD_DEPTH     = 4;
  localparam int RES_DEPTH     = 4;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_TEXT   = 1'b1;

  typedef struct packed {
    logic       operation;
    logic [7:0] symbol;
    logic       final_symbol;
  } cmd_t;

  typedef struct packed {
    logic [15:0] start_position;
    logic        is_match;
    logic        overflow_seen;
    logic        last_result;
  } result_t;
endpackage
`default_nettype wire

[sv/tmpm_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none
module tmpm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

[sv/tmpm_fifo.sv]
// Small register queue used between the front, the engine and the result port.
// No dependencies. DEPTH must be a power of two.
`default_nettype none
module tmpm_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] rdata,
  output logic                  empty
);
  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_r];

  always_comb begin
    wr_nxt  = do_push ? wr_r + PW'(1) : wr_r;
    rd_nxt  = do_pop ? rd_r + PW'(1) : rd_r;
    cnt_nxt = cnt_r + CW'(do_push) - CW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
    if (do_push) begin
      mem_r[wr_r] <= wdata;
    end
  end
endmodule
`default_nettype wire

[sv/tmpm_engine.sv]
// Back end of the matcher: trie insertion, lookahead window and trie walks.
// Depends on tmpm_pkg and tmpm_ram.
`default_nettype none
module tmpm_engine #(
  parameter int NODES     = tmpm_pkg::NODES_DEF,
  parameter int MAX_DEPTH = tmpm_pkg::MAX_DEPTH_DEF,
  parameter int TEXT_MAX  = tmpm_pkg::TEXT_MAX_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire tmpm_pkg::cmd_t   cmd,
  input  wire logic             cmd_valid,
  output logic                  cmd_pop,
  input  wire logic             res_full,
  output logic                  res_push,
  output tmpm_pkg::result_t     res
);
  localparam int NW = $clog2(NODES);
  localparam int UW = NW + 1;
  localparam int KW = $clog2(MAX_DEPTH + 1);
  localparam int IW = $clog2(MAX_DEPTH);
  localparam int PW = $clog2(TEXT_MAX + 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_FCQ   = 4'd1;
  localparam logic [3:0] S_FCD   = 4'd2;
  localparam logic [3:0] S_SSQ   = 4'd3;
  localparam logic [3:0] S_SSD   = 4'd4;
  localparam logic [3:0] S_ALLOC = 4'd5;
  localparam logic [3:0] S_LINK  = 4'd6;
  localparam logic [3:0] S_TXT   = 4'd7;
  localparam logic [3:0] S_RET   = 4'd8;
  localparam logic [3:0] S_MARK  = 4'd9;

  logic [3:0]    state_r, state_nxt;
  logic          walk_r, walk_nxt;
  logic [7:0]    sym_r, sym_nxt;
  logic          fin_r, fin_nxt;
  logic [NW-1:0] node_r, node_nxt, c_r, c_nxt, head_r, head_nxt;
  logic [NW-1:0] cursor_r, cursor_nxt, root_fc_r, root_fc_nxt;
  logic [UW-1:0] used_r, used_nxt;
  logic [KW-1:0] k_r, k_nxt, len_r, len_nxt, fill_r, fill_nxt;
  logic [PW-1:0] pos_r, pos_nxt;
  logic          match_r, match_nxt, ovf_r, ovf_nxt;
  logic [7:0]    win_r [MAX_DEPTH];
  logic [7:0]    win_nxt [MAX_DEPTH];

  logic             fc_we, ss_we;
  logic [NW-1:0]    fc_waddr, fc_wdata, fc_rdata, ss_waddr;
  logic [8+NW-1:0]  ss_wdata, ss_rdata;
  logic [NW-1:0]    fc_val, ss_sib;
  logic [7:0]       ss_sym, key;
  logic [PW-1:0]    start_full;

  tmpm_ram #(.WIDTH(NW), .DEPTH(NODES)) u_fc_ram (
    .clk, .we(fc_we), .waddr(fc_waddr), .wdata(fc_wdata),
    .raddr(node_r), .rdata(fc_rdata)
  );

  tmpm_ram #(.WIDTH(8 + NW), .DEPTH(NODES)) u_ss_ram (
    .clk, .we(ss_we), .waddr(ss_waddr), .wdata(ss_wdata),
    .raddr(c_r), .rdata(ss_rdata)
  );

  assign fc_val     = (node_r == '0) ? root_fc_r : fc_rdata;
  assign ss_sym     = ss_rdata[8+NW-1:NW];
  assign ss_sib     = ss_rdata[NW-1:0];
  assign key        = walk_r ? win_r[k_r[IW-1:0]] : sym_r;
  assign start_full = pos_r - PW'(fill_r);

  always_comb begin
    state_nxt   = state_r;
    walk_nxt    = walk_r;
    sym_nxt     = sym_r;
    fin_nxt     = fin_r;
    node_nxt    = node_r;
    c_nxt       = c_r;
    head_nxt    = head_r;
    cursor_nxt  = cursor_r;
    root_fc_nxt = root_fc_r;
    used_nxt    = used_r;
    k_nxt       = k_r;
    len_nxt     = len_r;
    fill_nxt    = fill_r;
    pos_nxt     = pos_r;
    match_nxt   = match_r;
    ovf_nxt     = ovf_r;
    win_nxt     = win_r;
    cmd_pop     = 1'b0;
    res_push    = 1'b0;
    res         = '0;
    fc_we       = 1'b0;
    fc_waddr    = node_r;
    fc_wdata    = '0;
    ss_we       = 1'b0;
    ss_waddr    = used_r[NW-1:0];
    ss_wdata    = {sym_r, head_r};

    unique case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          sym_nxt = cmd.symbol;
          fin_nxt = cmd.final_symbol;
          if (cmd.operation == tmpm_pkg::OP_INSERT) begin
            walk_nxt  = 1'b0;
            node_nxt  = cursor_r;
            state_nxt = S_FCQ;
          end else begin
            if (pos_r < PW'(TEXT_MAX)) begin
              win_nxt[fill_r[IW-1:0]] = cmd.symbol;
              fill_nxt = fill_r + KW'(1);
              pos_nxt  = pos_r + PW'(1);
            end else begin
              ovf_nxt = 1'b1;
            end
            state_nxt = S_TXT;
          end
        end
      end
      S_FCQ: state_nxt = S_FCD;
      S_FCD: begin
        head_nxt = fc_val;
        c_nxt    = fc_val;
        if (walk_r) begin
          if (fc_val == '0) begin
            match_nxt = 1'b1;
            state_nxt = S_RET;
          end else if (k_r >= len_r) begin
            match_nxt = 1'b0;
            state_nxt = S_RET;
          end else begin
            state_nxt = S_SSQ;
          end
        end else begin
          state_nxt = (fc_val == '0) ? S_ALLOC : S_SSQ;
        end
      end
      S_SSQ: state_nxt = S_SSD;
      S_SSD: begin
        if (ss_sym == key) begin
          node_nxt = c_r;
          if (walk_r) begin
            k_nxt     = k_r + KW'(1);
            state_nxt = S_FCQ;
          end else begin
            cursor_nxt = fin_r ? '0 : c_r;
            state_nxt  = S_IDLE;
          end
        end else if (ss_sib == '0) begin
          match_nxt = 1'b0;
          state_nxt = walk_r ? S_RET : S_ALLOC;
        end else begin
          c_nxt     = ss_sib;
          state_nxt = S_SSQ;
        end
      end
      S_ALLOC: begin
        if (used_r < UW'(NODES)) begin
          ss_we     = 1'b1;
          fc_we     = 1'b1;
          fc_waddr  = used_r[NW-1:0];
          fc_wdata  = '0;
          state_nxt = S_LINK;
        end else begin
          ovf_nxt    = 1'b1;
          cursor_nxt = fin_r ? '0 : node_r;
          state_nxt  = S_IDLE;
        end
      end
      S_LINK: begin
        if (node_r == '0) begin
          root_fc_nxt = used_r[NW-1:0];
        end else begin
          fc_we    = 1'b1;
          fc_wdata = used_r[NW-1:0];
        end
        cursor_nxt = fin_r ? '0 : used_r[NW-1:0];
        used_nxt   = used_r + UW'(1);
        state_nxt  = S_IDLE;
      end
      S_TXT: begin
        if (fill_r == KW'(MAX_DEPTH) || (fin_r && fill_r != '0)) begin
          walk_nxt  = 1'b1;
          node_nxt  = '0;
          k_nxt     = '0;
          len_nxt   = fill_r;
          state_nxt = S_FCQ;
        end else if (fin_r) begin
          state_nxt = S_MARK;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_RET: begin
        if (!(match_r && res_full)) begin
          res_push = match_r;
          res.start_position = start_full[15:0];
          res.is_match       = 1'b1;
          res.overflow_seen  = ovf_r;
          res.last_result    = 1'b0;
          for (int i = 0; i < MAX_DEPTH - 1; i++) begin
            win_nxt[i] = win_r[i+1];
          end
          fill_nxt  = fill_r - KW'(1);
          state_nxt = S_TXT;
        end
      end
      S_MARK: begin
        if (!res_full) begin
          res_push          = 1'b1;
          res.overflow_seen = ovf_r;
          res.last_result   = 1'b1;
          fill_nxt          = '0;
          pos_nxt           = '0;
          state_nxt         = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      cursor_r  <= '0;
      root_fc_r <= '0;
      used_r    <= UW'(1);
      fill_r    <= '0;
      pos_r     <= '0;
      ovf_r     <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cursor_r  <= cursor_nxt;
      root_fc_r <= root_fc_nxt;
      used_r    <= used_nxt;
      fill_r    <= fill_nxt;
      pos_r     <= pos_nxt;
      ovf_r     <= ovf_nxt;
    end
    walk_r  <= walk_nxt;
    sym_r   <= sym_nxt;
    fin_r   <= fin_nxt;
    node_r  <= node_nxt;
    c_r     <= c_nxt;
    head_r  <= head_nxt;
    k_r     <= k_nxt;
    len_r   <= len_nxt;
    match_r <= match_nxt;
    win_r   <= win_nxt;
  end
endmodule
`default_nettype wire

[sv/trie_multi_pattern_matcher.sv]
// Trie multi-pattern matcher, top level. A transfer is registered in the input queue.
// A pattern symbol then passes IDLE, FCQ, FCD, plus SSQ, SSD per sibling scanned and ALLOC,
// LINK to allocate. A text symbol passes IDLE, TXT, plus per retired position FCQ, FCD
// per trie level, SSQ, SSD per sibling and RET; the end marker adds MARK, and a result is
// registered in the output queue. The engine holds one item at a time. Reset (synchronous,
// rst_n low) empties both queues, leaves only the root and clears window, position, flag.
`default_nettype none
module trie_multi_pattern_matcher #(
  parameter int NODES     = tmpm_pkg::NODES_DEF,
  parameter int MAX_DEPTH = tmpm_pkg::MAX_DEPTH_DEF,
  parameter int TEXT_MAX  = tmpm_pkg::TEXT_MAX_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  output logic             full,
  input  wire logic        in_operation,
  input  wire logic [7:0]  in_symbol,
  input  wire logic        in_final_symbol,
  output logic             empty,
  input  wire logic        pop,
  output logic [15:0]      out_start_position,
  output logic             out_is_match,
  output logic             out_overflow_seen,
  output logic             out_last_result
);
  // The input queue holds four transfers so the sender can run ahead of a walk
  // that is still in progress; full is raised once every entry is taken.
  tmpm_pkg::cmd_t    in_cmd, eng_cmd;
  tmpm_pkg::result_t eng_res, out_res;
  logic              cmd_empty, cmd_pop, res_full, res_push;

  assign in_cmd.operation    = in_operation;
  assign in_cmd.symbol       = in_symbol;
  assign in_cmd.final_symbol = in_final_symbol;

  tmpm_fifo #(.WIDTH($bits(tmpm_pkg::cmd_t)), .DEPTH(tmpm_pkg::CMD_DEPTH)) u_cmd_q (
    .clk, .rst_n, .push(push), .wdata(in_cmd), .full(full),
    .pop(cmd_pop), .rdata(eng_cmd), .empty(cmd_empty)
  );

  // The engine inserts pattern symbols and walks the trie once per start position.
  tmpm_engine #(.NODES(NODES), .MAX_DEPTH(MAX_DEPTH), .TEXT_MAX(TEXT_MAX)) u_engine (
    .clk, .rst_n, .cmd(eng_cmd), .cmd_valid(!cmd_empty), .cmd_pop,
    .res_full, .res_push, .res(eng_res)
  );

  // Results wait here until the consumer takes them; the engine stalls when full.
  tmpm_fifo #(.WIDTH($bits(tmpm_pkg::result_t)), .DEPTH(tmpm_pkg::RES_DEPTH)) u_res_q (
    .clk, .rst_n, .push(res_push), .wdata(eng_res), .full(res_full),
    .pop(pop), .rdata(out_res), .empty(empty)
  );

  assign out_start_position = out_res.start_position;
  assign out_is_match       = out_res.is_match;
  assign out_overflow_seen  = out_res.overflow_seen;
  assign out_last_result    = out_res.last_result;

  // Both queues come out of reset empty.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty && !full)
    else $error("queues not empty after reset");

  // The end marker never carries a match and always reports position zero.
  a_marker: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && out_last_result |-> !out_is_match && out_start_position == 16'd0)
    else $error("malformed end marker");

  // The engine only pushes when the result queue has room.
  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full)
    else $error("result pushed into a full queue");
endmodule
`default_nettype wire
